// ===== design/gpr_pkg.sv =====
// Shared types and constants for the geodesic point reflection unit.
// No dependencies.
package gpr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int RAD_W         = 31;
    localparam int PROD_W        = 66;
    localparam int DEN_W         = 66;
    localparam int NUM_W         = 97;
    localparam int SNUM_W        = NUM_W + 1;
    localparam int QBITS         = 35;
    localparam int CMP_W         = DEN_W + QBITS;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_KIND      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_VERTICAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SLOPE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_INTERCEPT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_X          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_Y          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRCLE_RADIUS  = 3'd6;

    localparam logic [1:0] FAULT_OK     = 2'd0;
    localparam logic [1:0] FAULT_CENTER = 2'd1;
    localparam logic [1:0] FAULT_SAT    = 2'd2;

    typedef struct packed {
        logic                      edge_kind;
        logic                      line_vertical;
        logic signed [COORD_W-1:0] line_slope;
        logic signed [COORD_W-1:0] line_intercept;
        logic signed [COORD_W-1:0] ref_x;
        logic signed [COORD_W-1:0] ref_y;
        logic [RAD_W-1:0]          circle_radius;
    } t_cfg;

    typedef struct packed {
        logic                      valid;
        logic [DEN_W-1:0]          den;
        logic [NUM_W-1:0]          rem_x;
        logic [NUM_W-1:0]          rem_y;
        logic [QBITS-1:0]          q_x;
        logic [QBITS-1:0]          q_y;
        logic                      neg_x;
        logic                      neg_y;
        logic                      center;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } t_cell;

endpackage

// ===== design/gpr_pt_if.sv =====
// Input point channel: valid/ready handshake with point payload.
// Depends on gpr_pkg.
interface gpr_pt_if import gpr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;

    modport source (output valid, point_x, point_y, input ready);
    modport sink   (input valid, point_x, point_y, output ready);
endinterface

// ===== design/gpr_img_if.sv =====
// Output image channel: valid/ready handshake with image payload and fault code.
// Depends on gpr_pkg.
interface gpr_img_if import gpr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] image_x;
    logic signed [COORD_W-1:0] image_y;
    logic [1:0]                fault;

    modport source (output valid, image_x, image_y, fault, input ready);
    modport sink   (input valid, image_x, image_y, fault, output ready);
endinterface

// ===== design/gpr_prep.sv =====
// Front end: offsets, products and numerator/denominator forming, five stages.
// Delivers the first divider cell beat. Depends on gpr_pkg.
module gpr_prep import gpr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  t_cfg                      i_cfg,
    input  logic                      i_valid,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    output t_cell                     o_cell
);

    // stage 1
    logic                      r1_valid;
    logic signed [COORD_W:0]   r1_dx, r1_dy, r1_ymb;
    logic [62:0]               r1_big;
    logic signed [COORD_W-1:0] r1_x, r1_y;
    logic [61:0]               w_rsq;
    logic signed [63:0]        w_msq;

    assign w_rsq = 62'(i_cfg.circle_radius) * 62'(i_cfg.circle_radius);
    assign w_msq = 64'(i_cfg.line_slope) * 64'(i_cfg.line_slope);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_dx  <= 33'(i_x) - 33'(i_cfg.ref_x);
            r1_dy  <= 33'(i_y) - 33'(i_cfg.ref_y);
            r1_ymb <= 33'(i_y) - 33'(i_cfg.line_intercept);
            r1_big <= i_cfg.edge_kind ? {1'b0, w_rsq} : w_msq[62:0];
            r1_x   <= i_x;
            r1_y   <= i_y;
        end
    end

    // stage 2
    logic                      r2_valid, r2_center;
    logic signed [PROD_W-1:0]  r2_p1, r2_p2, r2_phx, r2_plx, r2_phy, r2_ply;
    logic [62:0]               r2_big;
    logic signed [COORD_W-1:0] r2_x, r2_y;
    logic signed [COORD_W:0]   w_a1, w_b1, w_a2, w_b2, w_ux, w_uy, w_hi, w_lo;

    always_comb begin
        w_a1 = i_cfg.edge_kind ? r1_dx : 33'(i_cfg.line_slope);
        w_b1 = i_cfg.edge_kind ? r1_dx : 33'(r1_x);
        w_a2 = i_cfg.edge_kind ? r1_dy : 33'(i_cfg.line_slope);
        w_b2 = i_cfg.edge_kind ? r1_dy : r1_ymb;
        w_ux = r1_dx;
        w_uy = i_cfg.edge_kind ? r1_dy : 33'(r1_y);
        w_hi = $signed({1'b0, r1_big[62:31]});
        w_lo = $signed({2'b00, r1_big[30:0]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_p1     <= PROD_W'(w_a1) * PROD_W'(w_b1);
            r2_p2     <= PROD_W'(w_a2) * PROD_W'(w_b2);
            r2_phx    <= PROD_W'(w_hi) * PROD_W'(w_ux);
            r2_plx    <= PROD_W'(w_lo) * PROD_W'(w_ux);
            r2_phy    <= PROD_W'(w_hi) * PROD_W'(w_uy);
            r2_ply    <= PROD_W'(w_lo) * PROD_W'(w_uy);
            r2_big    <= r1_big;
            r2_center <= (r1_dx == '0) && (r1_dy == '0);
            r2_x      <= r1_x;
            r2_y      <= r1_y;
        end
    end

    // stage 3
    logic                      r3_valid, r3_center;
    logic signed [SNUM_W-1:0]  r3_nx, r3_ny;
    logic [DEN_W-1:0]          r3_den;
    logic signed [COORD_W-1:0] r3_x, r3_y;
    logic signed [SNUM_W-1:0]  w_cx, w_yy, w_lx, w_ly;
    logic [DEN_W:0]            w_csum;
    logic [DEN_W-1:0]          w_lden;

    always_comb begin
        w_cx   = (SNUM_W'(r2_phx) <<< 31) + SNUM_W'(r2_plx);
        w_yy   = (SNUM_W'(r2_phy) <<< 31) + SNUM_W'(r2_ply);
        w_lx   = (SNUM_W'(r2_x) <<< (2 * FRAC_BITS)) + (SNUM_W'(r2_p2) <<< FRAC_BITS);
        w_ly   = w_yy + (SNUM_W'(r2_p1) <<< FRAC_BITS)
               + (SNUM_W'(i_cfg.line_intercept) <<< (2 * FRAC_BITS));
        w_csum = (DEN_W + 1)'($unsigned(r2_p1)) + (DEN_W + 1)'($unsigned(r2_p2));
        w_lden = (DEN_W'(1) << (2 * FRAC_BITS)) + DEN_W'(r2_big);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r3_nx     <= i_cfg.edge_kind ? w_cx : w_lx;
            r3_ny     <= i_cfg.edge_kind ? w_yy : w_ly;
            r3_den    <= i_cfg.edge_kind ? w_csum[DEN_W-1:0] : w_lden;
            r3_center <= r2_center;
            r3_x      <= r2_x;
            r3_y      <= r2_y;
        end
    end

    // stage 4: sign and magnitude
    logic                      r4_valid, r4_center, r4_neg_x, r4_neg_y;
    logic [NUM_W-1:0]          r4_mx, r4_my;
    logic [DEN_W-1:0]          r4_den;
    logic signed [COORD_W-1:0] r4_x, r4_y;
    logic [SNUM_W-1:0]         w_ax, w_ay;

    assign w_ax = r3_nx[SNUM_W-1] ? $unsigned(-r3_nx) : $unsigned(r3_nx);
    assign w_ay = r3_ny[SNUM_W-1] ? $unsigned(-r3_ny) : $unsigned(r3_ny);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
        if (i_en) begin
            r4_mx     <= w_ax[NUM_W-1:0];
            r4_my     <= w_ay[NUM_W-1:0];
            r4_neg_x  <= r3_nx[SNUM_W-1];
            r4_neg_y  <= r3_ny[SNUM_W-1];
            r4_den    <= r3_den;
            r4_center <= r3_center;
            r4_x      <= r3_x;
            r4_y      <= r3_y;
        end
    end

    // stage 5: add half divisor for round to nearest
    t_cell r5_cell;
    t_cell n5_cell;

    always_comb begin
        n5_cell        = '0;
        n5_cell.valid  = r4_valid;
        n5_cell.den    = r4_den;
        n5_cell.rem_x  = r4_mx + NUM_W'(r4_den >> 1);
        n5_cell.rem_y  = r4_my + NUM_W'(r4_den >> 1);
        n5_cell.neg_x  = r4_neg_x;
        n5_cell.neg_y  = r4_neg_y;
        n5_cell.center = r4_center;
        n5_cell.px     = r4_x;
        n5_cell.py     = r4_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_cell <= '0;
        end else if (i_en) begin
            r5_cell <= n5_cell;
        end
    end

    assign o_cell = r5_cell;

endmodule

// ===== design/gpr_div_cell.sv =====
// One restoring divider cell: resolves one quotient bit for both lanes.
// Depends on gpr_pkg.
module gpr_div_cell import gpr_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cell i_cell,
    output t_cell o_cell
);

    logic [CMP_W-1:0] w_dsh;
    logic [CMP_W:0]   w_dx, w_dy;
    t_cell            n_cell, r_cell;

    assign w_dsh = CMP_W'(i_cell.den) << SHIFT;
    assign w_dx  = {1'b0, CMP_W'(i_cell.rem_x)} - {1'b0, w_dsh};
    assign w_dy  = {1'b0, CMP_W'(i_cell.rem_y)} - {1'b0, w_dsh};

    always_comb begin
        n_cell     = i_cell;
        n_cell.q_x = {i_cell.q_x[QBITS-2:0], !w_dx[CMP_W]};
        n_cell.q_y = {i_cell.q_y[QBITS-2:0], !w_dy[CMP_W]};
        if (!w_dx[CMP_W]) begin
            n_cell.rem_x = w_dx[NUM_W-1:0];
        end
        if (!w_dy[CMP_W]) begin
            n_cell.rem_y = w_dy[NUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

// ===== design/gpr_finish.sv =====
// Output stage: quotient clamp, edge case select, saturation, output register.
// Depends on gpr_pkg and gpr_img_if.
module gpr_finish import gpr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_cfg              i_cfg,
    input  t_cell             i_cell,
    gpr_img_if.source         o_img
);

    localparam int SUM_W = COORD_W + 6;

    function automatic logic [COORD_W:0] f_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            f_sat = {1'b1, hi[COORD_W-1:0]};
        end else if (v < lo) begin
            f_sat = {1'b1, lo[COORD_W-1:0]};
        end else begin
            f_sat = {1'b0, v[COORD_W-1:0]};
        end
    endfunction

    logic [QBITS-1:0]          w_qmx, w_qmy;
    logic signed [SUM_W-1:0]   w_sqx, w_sqy, w_rx, w_ry;
    logic [COORD_W:0]          w_sx, w_sy;
    logic                      r_valid;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic [1:0]                r_fault;

    always_comb begin
        w_qmx = i_cell.q_x[QBITS-1] ? (QBITS'(1) << (QBITS-1)) : i_cell.q_x;
        w_qmy = i_cell.q_y[QBITS-1] ? (QBITS'(1) << (QBITS-1)) : i_cell.q_y;
        w_sqx = i_cell.neg_x ? -$signed(SUM_W'(w_qmx)) : $signed(SUM_W'(w_qmx));
        w_sqy = i_cell.neg_y ? -$signed(SUM_W'(w_qmy)) : $signed(SUM_W'(w_qmy));
        if (i_cfg.edge_kind) begin
            w_rx = SUM_W'(i_cfg.ref_x) + w_sqx;
            w_ry = SUM_W'(i_cfg.ref_y) + w_sqy;
        end else if (i_cfg.line_vertical) begin
            w_rx = (SUM_W'(i_cfg.ref_x) <<< 1) - SUM_W'(i_cell.px);
            w_ry = SUM_W'(i_cell.py);
        end else if (i_cfg.line_slope == '0) begin
            w_rx = SUM_W'(i_cell.px);
            w_ry = (SUM_W'(i_cfg.ref_y) <<< 1) - SUM_W'(i_cell.py);
        end else begin
            w_rx = (w_sqx <<< 1) - SUM_W'(i_cell.px);
            w_ry = (w_sqy <<< 1) - SUM_W'(i_cell.py);
        end
        w_sx = f_sat(w_rx);
        w_sy = f_sat(w_ry);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_cell.valid;
        end
        if (i_en) begin
            if (i_cfg.edge_kind && i_cell.center) begin
                r_x     <= '0;
                r_y     <= '0;
                r_fault <= FAULT_CENTER;
            end else begin
                r_x     <= $signed(w_sx[COORD_W-1:0]);
                r_y     <= $signed(w_sy[COORD_W-1:0]);
                r_fault <= (w_sx[COORD_W] || w_sy[COORD_W]) ? FAULT_SAT : FAULT_OK;
            end
        end
    end

    assign o_img.valid   = r_valid;
    assign o_img.image_x = r_x;
    assign o_img.image_y = r_y;
    assign o_img.fault   = r_fault;

endmodule

// ===== design/geodesic_point_reflection_unit.sv =====
// Point reflection in a line or inversion in a circle, Q16.16 fixed point.
// Pipeline: 5 front-end stages, 35 divider cells, 1 output register.
// Throughput one beat per cycle; the whole pipeline stalls while a result waits.
// Synchronous reset clears all valid bits and loads the register reset values.
// Depends on gpr_pkg, gpr_pt_if, gpr_img_if, gpr_prep, gpr_div_cell, gpr_finish.
module geodesic_point_reflection_unit import gpr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_W-1:0]   i_cfg_data,
    gpr_pt_if.sink               i_pt,
    gpr_img_if.source            o_img
);

    t_cfg  r_cfg;
    logic  w_en;
    t_cell w_cell [QBITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{circle_radius: RAD_W'(1) << FRAC_BITS, default: '0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EDGE_KIND:      r_cfg.edge_kind      <= i_cfg_data[0];
                CFG_LINE_VERTICAL:  r_cfg.line_vertical  <= i_cfg_data[0];
                CFG_LINE_SLOPE:     r_cfg.line_slope     <= $signed(i_cfg_data);
                CFG_LINE_INTERCEPT: r_cfg.line_intercept <= $signed(i_cfg_data);
                CFG_REF_X:          r_cfg.ref_x          <= $signed(i_cfg_data);
                CFG_REF_Y:          r_cfg.ref_y          <= $signed(i_cfg_data);
                CFG_CIRCLE_RADIUS:  r_cfg.circle_radius  <= i_cfg_data[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_en       = !o_img.valid || o_img.ready;
    assign i_pt.ready = w_en;

    gpr_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_valid (i_pt.valid),
        .i_x     (i_pt.point_x),
        .i_y     (i_pt.point_y),
        .o_cell  (w_cell[0])
    );

    for (genvar k = 0; k < QBITS; k++) begin : g_cell
        gpr_div_cell #(.SHIFT(QBITS - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cell  (w_cell[k]),
            .o_cell  (w_cell[k+1])
        );
    end

    gpr_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_cell  (w_cell[QBITS]),
        .o_img   (o_img)
    );

    a_center_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_img.valid && o_img.fault == FAULT_CENTER) |->
            (o_img.image_x == '0 && o_img.image_y == '0))
        else $error("center fault with nonzero image");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_img.valid && !o_img.ready) |-> !i_pt.ready)
        else $error("input taken while result stalled");

    a_last_cell_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cell[QBITS].valid && w_en) |=> o_img.valid)
        else $error("divider beat lost at output");

endmodule
